// ===== rtl/dccl_pkg.sv =====
// Shared types and constants for the daisy chain cell link master.
// No dependencies.
package dccl_pkg;

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_RX      = 3'd1;
   localparam logic [2:0] MODE_READ    = 3'd2;
   localparam logic [2:0] MODE_WRITE   = 3'd3;
   localparam logic [2:0] MODE_CONNECT = 3'd4;

   localparam logic [2:0] KIND_TX       = 3'd0;
   localparam logic [2:0] KIND_CONN     = 3'd1;
   localparam logic [2:0] KIND_CELL     = 3'd2;
   localparam logic [2:0] KIND_DISC     = 3'd3;
   localparam logic [2:0] KIND_DROP     = 3'd4;
   localparam logic [2:0] KIND_REJECT   = 3'd5;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_TIMEOUT = 2'd1;
   localparam logic [1:0] ERR_CRC     = 2'd2;
   localparam logic [1:0] ERR_NORESP  = 2'd3;

   localparam logic       CSR_TIMEOUT  = 1'b0;
   localparam logic       CSR_ADDR_REG = 1'b1;

   localparam logic [7:0] CRC_POLY = 8'h07;

   // One result item.
   typedef struct packed {
      logic [1:0]  error_code;
      logic [6:0]  cells_found;
      logic [15:0] cell_voltage;
      logic [6:0]  cell_number;
      logic [7:0]  tx_byte;
      logic [2:0]  kind;
   } result_type;

   // Request queue entry.
   typedef struct packed {
      logic [7:0]  id;
      logic [6:0]  addr;
      logic [6:0]  register_num;
      logic        wr;
      logic [15:0] value;
   } entry_type;

endpackage

// ===== rtl/dccl_crc.sv =====
// Bit-serial CRC-8 (poly 0x07) unit, one bit per cycle.
// Depends on dccl_pkg.
module dccl_crc
   import dccl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,     // load crc ^ data and run eight steps
   input  logic [7:0] crc_init,
   input  logic [7:0] data,
   output logic       busy,
   output logic [7:0] crc_out
);
   logic [7:0] d_ff, d_in;
   logic [3:0] cnt_ff, cnt_in;

   always_comb begin
      d_in   = d_ff;
      cnt_in = cnt_ff;
      if (start) begin
         d_in   = crc_init ^ data;
         cnt_in = 4'd8;
      end else if (cnt_ff != 4'd0) begin
         d_in   = d_ff[7] ? ({d_ff[6:0], 1'b0} ^ CRC_POLY) : {d_ff[6:0], 1'b0};
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      d_ff <= d_in;
   end

   assign busy    = (cnt_ff != 4'd0);
   assign crc_out = d_ff;
endmodule

// ===== rtl/daisy_chain_cell_link_master.sv =====
// Daisy chain cell link master: after an item is accepted, req_tready stays low
// while it runs through the execute and send states for a tick, an ignored byte
// or a queued request with nothing to send. A byte gathered into a reply also
// passes through the bit-serial CRC-8 unit. A disconnect first clears the voltage
// table, one entry per cycle. Sending a request reads the queue once and runs the
// CRC over five bytes in the same unit; the six transmit bytes then go out. A
// result that comes before a send goes out first. A low rsp_tready stalls each
// output. Each result is held in an output register until taken, and tlast marks
// the final result of an item.
// Depends on dccl_pkg and dccl_crc.
module daisy_chain_cell_link_master
   import dccl_pkg::*;
#(
   parameter int CELL_SLOTS  = 16,
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tuser from bit 0: mode[2:0]
   input  logic [2:0]  req_tuser,
   // tdata from bit 0: rx_byte[7:0], target_cell[14:8], target_register[21:15],
   // write_value[37:22], zero fill to 40 bits
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tuser from bit 0: kind[2:0]
   output logic [2:0]  rsp_tuser,
   // tdata from bit 0: tx_byte[7:0], cell_number[14:8], cell_voltage[30:15],
   // cells_found[37:31], error_code[39:38]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EXEC  = 4'd1;
   localparam logic [3:0] ST_RXCRC = 4'd2;
   localparam logic [3:0] ST_OUT   = 4'd3;
   localparam logic [3:0] ST_CLEAR = 4'd4;
   localparam logic [3:0] ST_SEND  = 4'd5;
   localparam logic [3:0] ST_RDQ   = 4'd6;
   localparam logic [3:0] ST_TXCRC = 4'd7;
   localparam logic [3:0] ST_TXOUT = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [6:0]  addr_reg_ff, addr_reg_in;

   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  rx_ff, rx_in;
   logic [6:0]  cell_ff, cell_in;
   logic [6:0]  treg_ff, treg_in;
   logic [15:0] wval_ff, wval_in;

   entry_type   fifo_mem [QUEUE_DEPTH];
   entry_type   rd_ff;
   logic        fifo_we;
   entry_type   fifo_wd;
   logic [QW-1:0] fifo_wa;
   logic [QW:0]   wa_sum;
   logic [QW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   logic [15:0] volt_mem [CELL_SLOTS];
   logic        volt_we;
   logic [SW-1:0] volt_wa;
   logic [15:0] volt_wd;

   logic [7:0]  rb_ff [5];
   logic [7:0]  rb_in [5];
   logic [2:0]  rcnt_ff, rcnt_in;
   logic [7:0]  rcrc_ff, rcrc_in;
   logic        await_ff, await_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        up_ff, up_in;
   logic        conn_ff, conn_in;
   logic [6:0]  known_ff, known_in;
   logic [7:0]  pid_ff, pid_in;

   result_type  res_ff, res_in;
   logic        res_last_ff, res_last_in;
   logic        pend_ff, pend_in;   // a result of this item waits to go out
   logic [3:0]  ret_ff, ret_in;     // state after the output is taken
   logic [SW-1:0] clr_ff, clr_in;
   logic [7:0]  pk_ff [6];
   logic [7:0]  pk_in [6];
   logic [2:0]  bi_ff, bi_in;

   logic        crc_start;
   logic [7:0]  crc_init, crc_data, crc_out;
   logic        crc_busy;

   dccl_crc u_crc (
      .clock    (clock),
      .reset    (reset),
      .start    (crc_start),
      .crc_init (crc_init),
      .data     (crc_data),
      .busy     (crc_busy),
      .crc_out  (crc_out)
   );

   function automatic result_type mk(input logic [2:0] k, input logic [1:0] e);
      result_type r;
      r = '0;
      r.kind = k;
      r.error_code = e;
      return r;
   endfunction

   logic [6:0]  rep_addr;
   logic        rep_req;
   logic [15:0] rep_val;
   logic [15:0] elapsed_inc;

   assign rep_addr = rb_ff[1][7:1];
   assign rep_req  = rb_ff[1][0];
   assign rep_val  = {rb_ff[3], rb_ff[4]};
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;

   // tail slot, wrapped at the queue depth
   assign wa_sum  = {1'b0, head_ff} + {1'b0, count_ff[QW-1:0]};
   assign fifo_wa = (wa_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                    QW'(wa_sum - (QW+1)'(QUEUE_DEPTH)) : wa_sum[QW-1:0];

   always_comb begin
      state_in    = state_ff;
      timeout_in  = timeout_ff;
      addr_reg_in = addr_reg_ff;
      mode_in = mode_ff; rx_in = rx_ff; cell_in = cell_ff;
      treg_in = treg_ff; wval_in = wval_ff;
      head_in = head_ff; count_in = count_ff;
      rb_in = rb_ff; rcnt_in = rcnt_ff; rcrc_in = rcrc_ff;
      await_in = await_ff; elapsed_in = elapsed_ff;
      up_in = up_ff; conn_in = conn_ff; known_in = known_ff; pid_in = pid_ff;
      res_in = res_ff; res_last_in = res_last_ff;
      pend_in = pend_ff; ret_in = ret_ff; clr_in = clr_ff;
      pk_in = pk_ff; bi_in = bi_ff;
      fifo_we = 1'b0;
      fifo_wd = '0;
      volt_we = 1'b0;
      volt_wa = '0;
      volt_wd = '0;
      crc_start = 1'b0;
      crc_init = 8'h00;
      crc_data = 8'h00;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT:  timeout_in  = csr_wdata;
            CSR_ADDR_REG: addr_reg_in = csr_wdata[6:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               rx_in   = req_tdata[7:0];
               cell_in = req_tdata[14:8];
               treg_in = req_tdata[21:15];
               wval_in = req_tdata[37:22];
               pend_in = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_SEND;
            priority case (mode_ff)
               MODE_TICK: begin
                  if (await_ff) begin
                     elapsed_in = elapsed_inc;
                     if (elapsed_inc > timeout_ff) begin
                        up_in = 1'b0; conn_in = 1'b0; await_in = 1'b0;
                        elapsed_in = '0; head_in = '0; count_in = '0;
                        rcnt_in = '0; rcrc_in = '0;
                        res_in = mk(KIND_DISC, ERR_TIMEOUT);
                        pend_in = 1'b1;
                        clr_in = '0;
                        state_in = ST_CLEAR;
                     end
                  end
               end
               MODE_RX: begin
                  if (await_ff) begin
                     if (rcnt_ff < 3'd5) begin
                        rb_in[rcnt_ff] = rx_ff;
                        crc_start = 1'b1;
                        crc_init = rcrc_ff;
                        crc_data = rx_ff;
                        rcnt_in = rcnt_ff + 3'd1;
                        state_in = ST_RXCRC;
                     end else if (rx_ff != rcrc_ff) begin
                        rcnt_in = '0; rcrc_in = '0;
                        res_in = mk(KIND_REJECT, ERR_CRC);
                        pend_in = 1'b1;
                     end else begin
                        rcnt_in = '0; rcrc_in = '0;
                        await_in = 1'b0; elapsed_in = '0;
                        pend_in = 1'b1;
                        if (rep_addr == 7'd0) begin
                           if (!rep_req) begin
                              res_in = mk(KIND_REJECT, ERR_NORESP);
                           end else begin
                              up_in = 1'b1; conn_in = 1'b0;
                              if (rep_val == 16'd0) known_in = 7'd0;
                              else if (rep_val - 16'd1 > 16'd127) known_in = 7'd127;
                              else known_in = rep_val[6:0] - 7'd1;
                              res_in = mk(KIND_CONN, ERR_NONE);
                              res_in.cells_found = known_in;
                           end
                        end else if (rep_req) begin
                           res_in = mk(KIND_REJECT, ERR_NORESP);
                        end else begin
                           if ({1'b0, rep_addr} - 8'd1 < 8'(CELL_SLOTS)) begin
                              volt_we = 1'b1;
                              volt_wa = SW'(rep_addr - 7'd1);
                              volt_wd = rep_val;
                           end
                           res_in = mk(KIND_CELL, ERR_NONE);
                           res_in.cell_number = rep_addr;
                           res_in.cell_voltage = rep_val;
                        end
                     end
                  end
               end
               MODE_READ, MODE_WRITE, MODE_CONNECT: begin
                  pid_in = pid_ff + 8'd1;
                  fifo_wd.id = pid_ff;
                  if (mode_ff == MODE_CONNECT) begin
                     conn_in = 1'b1;
                     fifo_wd.addr = 7'd0;
                     fifo_wd.register_num = addr_reg_ff;
                     fifo_wd.wr = 1'b1;
                     fifo_wd.value = 16'd1;
                  end else begin
                     fifo_wd.addr = cell_ff;
                     fifo_wd.register_num = treg_ff;
                     fifo_wd.wr = (mode_ff == MODE_WRITE);
                     fifo_wd.value = (mode_ff == MODE_WRITE) ? wval_ff : 16'd0;
                  end
                  if (count_ff >= CW'(QUEUE_DEPTH)) begin
                     res_in = mk(KIND_DROP, ERR_NONE);
                     pend_in = 1'b1;
                  end else begin
                     fifo_we = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_RXCRC: begin
            if (!crc_busy) begin
               rcrc_in = crc_out;
               state_in = ST_SEND;
            end
         end
         ST_CLEAR: begin
            volt_we = 1'b1;
            volt_wa = clr_ff;
            volt_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == CELL_SLOTS - 1) state_in = ST_SEND;
         end
         ST_SEND: begin
            // hold the pending result until we know whether more follows
            if (!await_ff && count_ff != '0) begin
               if (pend_ff) begin
                  res_last_in = 1'b0;
                  ret_in = ST_RDQ;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_RDQ;
               end
            end else if (pend_ff) begin
               res_last_in = 1'b1;
               ret_in = ST_IDLE;
               state_in = ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               pend_in = 1'b0;
               state_in = ret_ff;
            end
         end
         ST_RDQ: begin
            pk_in[0] = rd_ff.id;
            pk_in[1] = {rd_ff.addr, 1'b1};
            pk_in[2] = {rd_ff.register_num, rd_ff.wr};
            pk_in[3] = rd_ff.value[15:8];
            pk_in[4] = rd_ff.value[7:0];
            head_in = (head_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            await_in = 1'b1; elapsed_in = '0; rcnt_in = '0; rcrc_in = '0;
            bi_in = '0;
            crc_start = 1'b1;
            crc_init = 8'h00;
            crc_data = rd_ff.id;
            state_in = ST_TXCRC;
         end
         ST_TXCRC: begin
            if (!crc_busy && !crc_start) begin
               if (bi_ff == 3'd4) begin
                  pk_in[5] = crc_out;
                  bi_in = '0;
                  res_in = mk(KIND_TX, ERR_NONE);
                  res_in.tx_byte = pk_ff[0];
                  res_last_in = 1'b0;
                  state_in = ST_TXOUT;
               end else begin
                  bi_in = bi_ff + 3'd1;
                  crc_start = 1'b1;
                  crc_init = crc_out;
                  crc_data = pk_ff[bi_ff + 3'd1];
               end
            end
         end
         ST_TXOUT: begin
            if (rsp_tready) begin
               if (bi_ff == 3'd5) begin
                  state_in = ST_IDLE;
               end else begin
                  bi_in = bi_ff + 3'd1;
                  res_in.tx_byte = pk_ff[bi_ff + 3'd1];
                  res_last_in = (bi_ff == 3'd4);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         timeout_ff <= 16'd100;
         addr_reg_ff <= '0;
         head_ff <= '0; count_ff <= '0;
         rcnt_ff <= '0; rcrc_ff <= '0;
         await_ff <= 1'b0; elapsed_ff <= '0;
         up_ff <= 1'b0; conn_ff <= 1'b0; known_ff <= '0; pid_ff <= '0;
         pend_ff <= 1'b0; ret_ff <= ST_IDLE;
         clr_ff <= '0; bi_ff <= '0;
      end else begin
         state_ff <= state_in;
         timeout_ff <= timeout_in;
         addr_reg_ff <= addr_reg_in;
         head_ff <= head_in; count_ff <= count_in;
         rcnt_ff <= rcnt_in; rcrc_ff <= rcrc_in;
         await_ff <= await_in; elapsed_ff <= elapsed_in;
         up_ff <= up_in; conn_ff <= conn_in; known_ff <= known_in; pid_ff <= pid_in;
         pend_ff <= pend_in; ret_ff <= ret_in;
         clr_ff <= clr_in; bi_ff <= bi_in;
      end
      mode_ff <= mode_in; rx_ff <= rx_in; cell_ff <= cell_in;
      treg_ff <= treg_in; wval_ff <= wval_in;
      rb_ff <= rb_in; res_ff <= res_in; res_last_ff <= res_last_in;
      pk_ff <= pk_in;
   end

   // queue memory, registered read at the head
   always_ff @(posedge clock) begin
      if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
      rd_ff <= fifo_mem[head_ff];
   end

   // voltage table is write-only storage here; it has no read port on the link
   always_ff @(posedge clock) begin
      if (volt_we) volt_mem[volt_wa] <= volt_wd;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT) || (state_ff == ST_TXOUT);
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tdata  = {res_ff.error_code, res_ff.cells_found, res_ff.cell_voltage,
                        res_ff.cell_number, res_ff.tx_byte};
   assign rsp_tlast  = res_last_ff;
endmodule
